[design/cpwm_pkg.sv]
// cpwm_pkg: shared types and constants of the complementary PWM block
// field widths, reset values of the settings registers, command and register codes
// no dependencies
package cpwm_pkg;

    localparam int OP_W       = 2;
    localparam int CH_W       = 2;
    localparam int DUTY_W     = 16;
    localparam int PERIOD_W   = 16;
    localparam int DEAD_W     = 15;
    localparam int DELAY_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4800;
    localparam logic [DEAD_W-1:0]   DEAD_RESET   = 15'd0;
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = 8'd60;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_SET_DUTY = 2'd1,
        OP_ENABLE   = 2'd2,
        OP_DISABLE  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 2'd0,
        CFG_DEAD   = 2'd1,
        CFG_DELAY  = 2'd2
    } t_cfg_idx;

endpackage

[design/cpwm_cmd_if.sv]
// cpwm_cmd_if: command channel of the complementary PWM block
// valid/ready handshake with op, channel and duty word; uses cpwm_pkg widths
interface cpwm_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [cpwm_pkg::OP_W-1:0]       op;
    logic [cpwm_pkg::CH_W-1:0]       channel;
    logic [cpwm_pkg::DUTY_W-1:0]     duty_value;

    modport source (output valid, output op, output channel, output duty_value, input ready);
    modport sink   (input valid, input op, input channel, input duty_value, output ready);
endinterface

[design/cpwm_res_if.sv]
// cpwm_res_if: result channel of the complementary PWM block
// valid/ready handshake with drive bits, period start flag and duty readback
interface cpwm_res_if #(
    parameter int CHANNELS = 3
);
    logic                            valid;
    logic                            ready;
    logic [CHANNELS-1:0]             high_drive;
    logic [CHANNELS-1:0]             low_drive;
    logic                            period_start;
    logic [cpwm_pkg::DUTY_W-1:0]     duty_readback;

    modport source (output valid, output high_drive, output low_drive,
                    output period_start, output duty_readback, input ready);
    modport sink   (input valid, input high_drive, input low_drive,
                    input period_start, input duty_readback, output ready);
endinterface

[design/complementary_pwm_dead_time.sv]
// complementary_pwm_dead_time: multi-channel complementary PWM with dead time
// depends on cpwm_pkg, cpwm_cmd_if and cpwm_res_if
//
//  channel   dir  word                                        handshake
//  i_cmd     in   op, channel, duty_value                     valid/ready
//  o_res     out  high_drive, low_drive, period_start,        valid/ready
//                 duty_readback
//  i_cfg_*   in   register index and data                     write enable only
//
// one word in, one word out, the result word registered; a word is taken every cycle
// while the result register is empty or being read in the same cycle
// the throughput is set by the single result register in front of o_res
// reset (i_rst_n low, synchronous) clears counter, duty stores, enables and
// result valid, and loads the default period, dead time and edge delay
// a stalled o_res holds its word and i_cmd.ready drops until it is taken
module complementary_pwm_dead_time #(
    parameter int CHANNELS    = 3,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    cpwm_cmd_if.sink                            i_cmd,
    cpwm_res_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [cpwm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cpwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // arithmetic width: holds user duty plus minimum and any counter value
    localparam int AW = (COUNT_WIDTH + 1 > 18) ? COUNT_WIDTH + 1 : 18;
    localparam int DW = cpwm_pkg::DUTY_W;

    logic [cpwm_pkg::PERIOD_W-1:0] r_period;
    logic [cpwm_pkg::DEAD_W-1:0]   r_dead;
    logic [cpwm_pkg::DELAY_W-1:0]  r_delay;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [DW-1:0]          r_pending [CHANNELS];
    logic [DW-1:0]          n_pending [CHANNELS];
    logic [DW-1:0]          r_active  [CHANNELS];
    logic [DW-1:0]          n_active  [CHANNELS];
    logic [CHANNELS-1:0]    r_enabled, n_enabled;

    logic                   r_out_valid;
    logic [CHANNELS-1:0]    r_high, n_high;
    logic [CHANNELS-1:0]    r_low, n_low;
    logic                   r_start, n_start;
    logic [DW-1:0]          r_readback, n_readback;

    logic                        w_accept;
    logic [cpwm_pkg::DEAD_W-1:0] w_eff_dead;
    logic [AW-1:0]               w_min;
    logic [AW-1:0]               w_rise;
    logic [AW-1:0]               w_period;
    logic [AW-1:0]               w_inc;
    logic                        w_wrap;
    logic                        w_ch_ok;
    logic [AW-1:0]               w_set_abs;
    logic [AW-1:0]               w_set_user;

    // absolute duty: user plus minimum, clamped to the period, then raised to the minimum
    function automatic logic [AW-1:0] abs_duty(input logic [DW-1:0] user,
                                               input logic [AW-1:0] mn,
                                               input logic [AW-1:0] per);
        logic [AW-1:0] d;
        d = AW'(user) + mn;
        if (d > per) d = per;
        if (d < mn) d = mn;
        return d;
    endfunction

    assign i_cmd.ready        = !r_out_valid || o_res.ready;
    assign w_accept           = i_cmd.valid && i_cmd.ready;

    assign o_res.valid         = r_out_valid;
    assign o_res.high_drive    = r_high;
    assign o_res.low_drive     = r_low;
    assign o_res.period_start  = r_start;
    assign o_res.duty_readback = r_readback;

    // dead time limited to half the period
    assign w_eff_dead = (r_dead > r_period[cpwm_pkg::PERIOD_W-1:1])
                      ? r_period[cpwm_pkg::PERIOD_W-1:1] : r_dead;
    assign w_min      = (AW'(w_eff_dead) << 1) + AW'(r_delay);
    assign w_rise     = AW'(w_eff_dead) + AW'(r_delay);
    assign w_period   = AW'(r_period);
    assign w_inc      = AW'(r_count) + AW'(1);
    assign w_wrap     = (w_inc >= w_period);
    assign w_ch_ok    = (32'(i_cmd.channel) < CHANNELS);
    assign w_set_abs  = abs_duty(i_cmd.duty_value, w_min, w_period);
    assign w_set_user = w_set_abs - w_min;

    // next state of counter, duty stores and enables, and the period start flag and readback
    always_comb begin
        n_count    = r_count;
        n_enabled  = r_enabled;
        n_pending  = r_pending;
        n_active   = r_active;
        n_start    = 1'b0;
        n_readback = '0;
        if (w_accept) begin
            unique case (cpwm_pkg::t_op'(i_cmd.op))
                cpwm_pkg::OP_TICK: begin
                    if (w_wrap) begin
                        n_count  = '0;
                        n_active = r_pending;
                        n_start  = 1'b1;
                    end else begin
                        n_count  = w_inc[COUNT_WIDTH-1:0];
                    end
                end
                cpwm_pkg::OP_SET_DUTY: begin
                    if (w_ch_ok) begin
                        n_readback = w_set_user[DW-1:0];
                        for (int i = 0; i < CHANNELS; i++) begin
                            if (32'(i_cmd.channel) == i) n_pending[i] = w_set_user[DW-1:0];
                        end
                    end
                end
                cpwm_pkg::OP_ENABLE: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (w_ch_ok && 32'(i_cmd.channel) == i) n_enabled[i] = 1'b1;
                    end
                end
                cpwm_pkg::OP_DISABLE: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (w_ch_ok && 32'(i_cmd.channel) == i) begin
                            n_enabled[i] = 1'b0;
                            n_pending[i] = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // drive bits from the counter position after this word
    always_comb begin
        logic [AW-1:0] d;
        logic [AW-1:0] fall;
        logic [AW-1:0] cnt;
        cnt    = AW'(n_count);
        n_high = '0;
        n_low  = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            d         = abs_duty(n_active[i], w_min, w_period);
            fall      = d - AW'(w_eff_dead);
            n_high[i] = n_enabled[i] && (cnt >= w_rise) && (cnt < fall);
            n_low[i]  = n_enabled[i] && (cnt >= d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= cpwm_pkg::PERIOD_RESET;
            r_dead      <= cpwm_pkg::DEAD_RESET;
            r_delay     <= cpwm_pkg::DELAY_RESET;
            r_count     <= '0;
            r_enabled   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_pending[i] <= '0;
                r_active[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (cpwm_pkg::t_cfg_idx'(i_cfg_idx))
                    cpwm_pkg::CFG_PERIOD: r_period <= i_cfg_data[cpwm_pkg::PERIOD_W-1:0];
                    cpwm_pkg::CFG_DEAD:   r_dead   <= i_cfg_data[cpwm_pkg::DEAD_W-1:0];
                    cpwm_pkg::CFG_DELAY:  r_delay  <= i_cfg_data[cpwm_pkg::DELAY_W-1:0];
                    default: ;
                endcase
            end
            r_count   <= n_count;
            r_enabled <= n_enabled;
            r_pending <= n_pending;
            r_active  <= n_active;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_high     <= n_high;
            r_low      <= n_low;
            r_start    <= n_start;
            r_readback <= n_readback;
        end
    end

    // the two sides of a pair never drive together
    a_no_shoot_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_high & r_low) == '0)
        else $error("high and low side active together");

    // a held word matches the enables it was built from
    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> ((r_high | r_low) & ~r_enabled) == '0)
        else $error("disabled channel drives an output");

    // a wrap only comes from a tick, which carries no readback
    a_wrap_no_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_start) |-> r_readback == '0)
        else $error("period start word carries a duty readback");

endmodule

[sim/complementary_pwm_dead_time_test.sv]
// complementary_pwm_dead_time_test: self-checking bench for the three-channel complementary pwm
// directed table then random phases over several period, dead time and delay settings
// depends on cpwm_pkg, cpwm_cmd_if, cpwm_res_if and complementary_pwm_dead_time
module complementary_pwm_dead_time_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS = 3;
    localparam int NUM_PHASES = 8;

    typedef struct packed {
        logic [CHANNELS-1:0]         hi;
        logic [CHANNELS-1:0]         lo;
        logic                        ps;
        logic [cpwm_pkg::DUTY_W-1:0] rb;
    } t_drive_word;

    // one line of the directed table: either a register write or a command word
    typedef struct packed {
        logic                      is_cfg;
        logic [1:0]                code;
        logic [cpwm_pkg::CH_W-1:0] chan;
        logic [15:0]               data;
        logic                      check;
        t_drive_word               want;
    } t_plan_row;

    typedef struct packed {
        logic        rnd;
        logic [15:0] per;
        logic [15:0] dead;
        logic [15:0] dly;
        logic [6:0]  idle;
        logic [6:0]  stall;
        logic [15:0] count;
    } t_phase;

    localparam t_drive_word QUIET = '0;

    localparam t_plan_row PLAN [35] = '{
        '{1'b0, cpwm_pkg::OP_TICK,     2'd0, 16'h0000, 1'b1, QUIET},
        '{1'b0, cpwm_pkg::OP_SET_DUTY, 2'd0, 16'hFFFF, 1'b1,
          '{3'b000, 3'b000, 1'b0, 16'd4740}},
        // channel three does not exist
        '{1'b0, cpwm_pkg::OP_SET_DUTY, 2'd3, 16'h1234, 1'b1, QUIET},
        '{1'b0, cpwm_pkg::OP_ENABLE,   2'd3, 16'h0000, 1'b1, QUIET},
        '{1'b0, cpwm_pkg::OP_DISABLE,  2'd3, 16'h0000, 1'b1, QUIET},
        '{1'b0, cpwm_pkg::OP_ENABLE,   2'd0, 16'h0000, 1'b0, QUIET},
        // period of zero and one wraps on every tick
        '{1'b1, cpwm_pkg::CFG_PERIOD,  2'd0, 16'h0000, 1'b0, QUIET},
        '{1'b1, cpwm_pkg::CFG_DEAD,    2'd0, 16'hFFFF, 1'b0, QUIET},
        '{1'b1, cpwm_pkg::CFG_DELAY,   2'd0, 16'hFF00, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_TICK,     2'd0, 16'h0000, 1'b0, QUIET},
        '{1'b1, cpwm_pkg::CFG_PERIOD,  2'd0, 16'h0001, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_TICK,     2'd0, 16'h0000, 1'b0, QUIET},
        // minimum duty above the period
        '{1'b1, cpwm_pkg::CFG_PERIOD,  2'd0, 16'hFFFF, 1'b0, QUIET},
        '{1'b1, cpwm_pkg::CFG_DEAD,    2'd0, 16'h7FFF, 1'b0, QUIET},
        '{1'b1, cpwm_pkg::CFG_DELAY,   2'd0, 16'h00FF, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_SET_DUTY, 2'd1, 16'hFFFF, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_ENABLE,   2'd1, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_TICK,     2'd0, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_DISABLE,  2'd1, 16'h0000, 1'b0, QUIET},
        // short period so that a whole cycle of the waveform fits
        '{1'b1, cpwm_pkg::CFG_PERIOD,  2'd0, 16'h0004, 1'b0, QUIET},
        '{1'b1, cpwm_pkg::CFG_DEAD,    2'd0, 16'h0001, 1'b0, QUIET},
        '{1'b1, cpwm_pkg::CFG_DELAY,   2'd0, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_SET_DUTY, 2'd0, 16'h0001, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_SET_DUTY, 2'd1, 16'h0009, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_ENABLE,   2'd1, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_SET_DUTY, 2'd2, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_ENABLE,   2'd2, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_DISABLE,  2'd2, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_ENABLE,   2'd2, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_TICK,     2'd0, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_TICK,     2'd0, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_TICK,     2'd0, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_TICK,     2'd0, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_TICK,     2'd0, 16'h0000, 1'b0, QUIET},
        '{1'b0, cpwm_pkg::OP_TICK,     2'd0, 16'h0000, 1'b0, QUIET}
    };

    localparam t_phase PHASES [NUM_PHASES] = '{
        '{1'b0, 16'd20,    16'd2,     16'd3,     7'd0,  7'd0,  16'd240},
        '{1'b0, 16'd50,    16'd5,     16'd0,     7'd74, 7'd0,  16'd240},
        '{1'b0, 16'd7,     16'd0,     16'd0,     7'd0,  7'd74, 16'd240},
        '{1'b0, 16'd2,     16'hFFFF,  16'h00FF,  7'd19, 7'd19, 16'd240},
        '{1'b0, 16'hFFFF,  16'h7FFF,  16'h00FF,  7'd0,  7'd0,  16'd240},
        '{1'b1, 16'd0,     16'd0,     16'd0,     7'd19, 7'd19, 16'd240},
        '{1'b0, 16'd4800,  16'd0,     16'd60,    7'd74, 7'd0,  16'd240},
        '{1'b1, 16'd0,     16'd0,     16'd0,     7'd0,  7'd74, 16'd240}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we;
    logic [cpwm_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [cpwm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    cpwm_cmd_if cmd_bus ();
    cpwm_res_if #(.CHANNELS(CHANNELS)) res_bus ();

    complementary_pwm_dead_time #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (16)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    int unsigned reg_period;
    int unsigned reg_dead;
    int unsigned reg_delay;
    int unsigned pwm_count;
    int unsigned duty_pending [CHANNELS];
    int unsigned duty_active [CHANNELS];
    logic [CHANNELS-1:0] chan_on;

    t_drive_word drive_expected [$];
    t_drive_word want_w;
    int mismatch_count;
    int idle_pct;
    int stall_pct;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned dead_eff();
        return (reg_dead > (reg_period >> 1)) ? (reg_period >> 1) : reg_dead;
    endfunction

    function automatic int unsigned duty_base();
        return (dead_eff() << 1) + reg_delay;
    endfunction

    function automatic int unsigned duty_abs(input int unsigned user);
        int unsigned base_v;
        int unsigned d;
        base_v = duty_base();
        d = user + base_v;
        if (d > reg_period) d = reg_period;
        if (d < base_v) d = base_v;
        return d;
    endfunction

    task automatic step_pwm(input cpwm_pkg::t_op op, input logic [cpwm_pkg::CH_W-1:0] ch,
                            input logic [cpwm_pkg::DUTY_W-1:0] dv, output t_drive_word w);
        int unsigned d;
        int unsigned fall;
        int unsigned rise;
        int unsigned user;
        w = '0;
        case (op)
            cpwm_pkg::OP_TICK: begin
                if (pwm_count + 1 >= reg_period) begin
                    pwm_count = 0;
                    duty_active = duty_pending;
                    w.ps = 1'b1;
                end else begin
                    pwm_count = (pwm_count + 1) & 32'hFFFF;
                end
            end
            cpwm_pkg::OP_SET_DUTY: begin
                if (ch < CHANNELS) begin
                    user = (duty_abs(dv) - duty_base()) & 32'hFFFF;
                    duty_pending[ch] = user;
                    w.rb = user[cpwm_pkg::DUTY_W-1:0];
                end
            end
            cpwm_pkg::OP_ENABLE: begin
                if (ch < CHANNELS) chan_on[ch] = 1'b1;
            end
            default: begin
                if (ch < CHANNELS) begin
                    chan_on[ch] = 1'b0;
                    duty_pending[ch] = 0;
                end
            end
        endcase
        rise = dead_eff() + reg_delay;
        for (int i = 0; i < CHANNELS; i++) begin
            if (chan_on[i]) begin
                d = duty_abs(duty_active[i]);
                fall = d - dead_eff();
                if (pwm_count >= rise && pwm_count < fall) w.hi[i] = 1'b1;
                if (pwm_count >= d) w.lo[i] = 1'b1;
            end
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(input cpwm_pkg::t_cfg_idx idx,
                             input logic [cpwm_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cpwm_pkg::CFG_PERIOD: reg_period = data;
            cpwm_pkg::CFG_DEAD:   reg_dead = data & 16'h7FFF;
            default:              reg_delay = data[7:0];
        endcase
        @(negedge i_clk);
    endtask

    // the sender goes quiet first so that the last word is not taken again
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        while (drive_expected.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic send_word(input cpwm_pkg::t_op op, input logic [cpwm_pkg::CH_W-1:0] ch,
                             input logic [cpwm_pkg::DUTY_W-1:0] dv, input logic typed,
                             input t_drive_word typed_w);
        t_drive_word w;
        while ($urandom_range(0, 99) < idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.op <= op;
        cmd_bus.channel <= ch;
        cmd_bus.duty_value <= dv;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        step_pwm(op, ch, dv, w);
        drive_expected.push_back(typed ? typed_w : w);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (drive_expected.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: word with nothing expected, got hi=%b lo=%b ps=%b rb=%0d",
                         $time, res_bus.high_drive, res_bus.low_drive,
                         res_bus.period_start, res_bus.duty_readback);
            end else begin
                want_w = drive_expected.pop_front();
                if (res_bus.high_drive !== want_w.hi) begin
                    mismatch_count++;
                    $display("%0t ns: high_drive expected %b got %b",
                             $time, want_w.hi, res_bus.high_drive);
                end
                if (res_bus.low_drive !== want_w.lo) begin
                    mismatch_count++;
                    $display("%0t ns: low_drive expected %b got %b",
                             $time, want_w.lo, res_bus.low_drive);
                end
                if (res_bus.period_start !== want_w.ps) begin
                    mismatch_count++;
                    $display("%0t ns: period_start expected %b got %b",
                             $time, want_w.ps, res_bus.period_start);
                end
                if (res_bus.duty_readback !== want_w.rb) begin
                    mismatch_count++;
                    $display("%0t ns: duty_readback expected %0d got %0d",
                             $time, want_w.rb, res_bus.duty_readback);
                end
            end
        end
    end

    initial begin
        int unsigned pick;
        cpwm_pkg::t_op op_v;
        logic [cpwm_pkg::CH_W-1:0] ch_v;
        logic [cpwm_pkg::DUTY_W-1:0] dv_v;
        logic [15:0] per_v;
        logic [15:0] dead_v;
        logic [15:0] dly_v;

        cmd_bus.valid = 1'b0;
        cmd_bus.op = cpwm_pkg::OP_TICK;
        cmd_bus.channel = '0;
        cmd_bus.duty_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = cpwm_pkg::CFG_PERIOD;
        i_cfg_data = '0;
        mismatch_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        reg_period = cpwm_pkg::PERIOD_RESET;
        reg_dead = cpwm_pkg::DEAD_RESET;
        reg_delay = cpwm_pkg::DELAY_RESET;
        pwm_count = 0;
        chan_on = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            duty_pending[i] = 0;
            duty_active[i] = 0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (PLAN[k]) begin
            if (PLAN[k].is_cfg) begin
                wait_drained();
                write_reg(cpwm_pkg::t_cfg_idx'(PLAN[k].code), PLAN[k].data);
            end else begin
                send_word(cpwm_pkg::t_op'(PLAN[k].code), PLAN[k].chan, PLAN[k].data,
                          PLAN[k].check, PLAN[k].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            if (PHASES[p].rnd) begin
                per_v = 16'($urandom_range(2, 300));
                dead_v = {1'($urandom_range(0, 1)), 15'($urandom_range(0, per_v / 2 + 3))};
                dly_v = {8'($urandom), 8'($urandom_range(0, 20))};
            end else begin
                per_v = PHASES[p].per;
                dead_v = PHASES[p].dead;
                dly_v = PHASES[p].dly;
            end
            write_reg(cpwm_pkg::CFG_PERIOD, per_v);
            write_reg(cpwm_pkg::CFG_DEAD, dead_v);
            write_reg(cpwm_pkg::CFG_DELAY, dly_v);
            idle_pct = PHASES[p].idle;
            stall_pct = PHASES[p].stall;
            repeat (PHASES[p].count) begin
                // ticks dominate so that the counter wraps and new duties go live
                pick = $urandom_range(0, 99);
                if (pick < 60) op_v = cpwm_pkg::OP_TICK;
                else if (pick < 80) op_v = cpwm_pkg::OP_SET_DUTY;
                else if (pick < 92) op_v = cpwm_pkg::OP_ENABLE;
                else op_v = cpwm_pkg::OP_DISABLE;
                ch_v = ($urandom_range(0, 11) == 0) ? 2'd3
                                                   : cpwm_pkg::CH_W'($urandom_range(0, 2));
                case ($urandom_range(0, 3))
                    0: dv_v = cpwm_pkg::DUTY_W'($urandom);
                    1: dv_v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: dv_v = cpwm_pkg::DUTY_W'($urandom_range(0, reg_period + 2));
                endcase
                send_word(op_v, ch_v, dv_v, 1'b0, QUIET);
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && drive_expected.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
